### rtl/lbe_pkg.sv
// Shared constants and types for the label boundary eraser.
`default_nettype none
package lbe_pkg;

   localparam int MAX_ROW_LENGTH_DEF = 1024;
   localparam int LABEL_WIDTH_DEF    = 32;

   localparam int PIXEL_W    = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int ROW_LEN_W   = 11;
   localparam int ROW_CNT_W   = 16;

   localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RESET = 11'd1024;
   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET  = 16'd1024;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_LENGTH = 2'd0,
      CSR_ROW_COUNT  = 2'd1
   } csr_index_type;

   // position of the request within the frame
   typedef struct packed {
      logic produce;     // a row above exists, so a result leaves
      logic up_valid;    // two rows above exist
      logic col_first;
      logic col_last;
      logic frame_last;
      logic blank;       // request lies below the slice
   } step_flags_type;

endpackage
`default_nettype wire

### rtl/lbe_frame_ctrl.sv
// Register file and column/row counters of the label boundary eraser.
`default_nettype none
module lbe_frame_ctrl #(
   parameter int MAX_ROW_LENGTH = lbe_pkg::MAX_ROW_LENGTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                accept,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [lbe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire  [lbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic [$clog2(MAX_ROW_LENGTH)-1:0]  col,
   output logic [$clog2(MAX_ROW_LENGTH)-1:0]  col_next,
   output lbe_pkg::step_flags_type            flags
);
   import lbe_pkg::*;

   localparam int CW = $clog2(MAX_ROW_LENGTH);
   localparam int LW = CW + 1;

   logic [ROW_LEN_W-1:0] row_length_ff;
   logic [ROW_CNT_W-1:0] row_count_ff;
   logic [CW-1:0]        col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic [LW-1:0]        len;
   logic [ROW_CNT_W-1:0] rows;
   logic [ROW_CNT_W:0]   row_inc;
   logic                 csr_hit;
   logic                 col_last;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && (csr_index == CSR_ROW_LENGTH || csr_index == CSR_ROW_COUNT);

   // zero length acts as one, oversize as the line buffer depth
   always_comb begin
      if (row_length_ff == '0) begin
         len = LW'(1);
      end else if (32'(row_length_ff) > 32'(MAX_ROW_LENGTH)) begin
         len = LW'(MAX_ROW_LENGTH);
      end else begin
         len = LW'(row_length_ff);
      end
      rows = (row_count_ff == '0) ? ROW_CNT_W'(1) : row_count_ff;
   end

   assign col_last = (LW'(col_ff) + LW'(1)) == len;
   assign row_inc  = {1'b0, row_ff} + (ROW_CNT_W+1)'(1);
   assign col      = col_ff;
   assign col_next = col_last ? '0 : col_ff + CW'(1);

   always_comb begin
      flags.produce    = row_ff != '0;
      flags.up_valid   = row_ff >= ROW_CNT_W'(2);
      flags.col_first  = col_ff == '0;
      flags.col_last   = col_last;
      flags.frame_last = (row_ff == rows) && col_last;
      flags.blank      = row_ff >= rows;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         col_in = col_next;
         if (col_last) begin
            row_in = (row_inc > {1'b0, rows}) ? '0 : row_inc[ROW_CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_valid && csr_index == CSR_ROW_LENGTH) begin
            row_length_ff <= csr_wdata[ROW_LEN_W-1:0];
         end
         if (csr_valid && csr_index == CSR_ROW_COUNT) begin
            row_count_ff <= csr_wdata[ROW_CNT_W-1:0];
         end
      end
   end

endmodule
`default_nettype wire

### rtl/lbe_line_store.sv
// Row buffers and the input register stage of the label boundary eraser.
`default_nettype none
module lbe_line_store #(
   parameter int MAX_ROW_LENGTH = lbe_pkg::MAX_ROW_LENGTH_DEF,
   parameter int LABEL_WIDTH    = lbe_pkg::LABEL_WIDTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                accept,
   input  wire                                move,
   input  wire  [lbe_pkg::PIXEL_W-1:0]        pixel_label,
   input  wire                                flush,
   input  wire  [$clog2(MAX_ROW_LENGTH)-1:0]  col,
   input  wire  [$clog2(MAX_ROW_LENGTH)-1:0]  col_next,
   input  lbe_pkg::step_flags_type            flags,
   output logic                               s1_valid,
   output lbe_pkg::step_flags_type            s1_flags,
   output logic [LABEL_WIDTH-1:0]             s1_below,
   output logic [LABEL_WIDTH-1:0]             s1_centre,
   output logic [LABEL_WIDTH-1:0]             s1_right,
   output logic [LABEL_WIDTH-1:0]             s1_up
);
   import lbe_pkg::*;

   localparam int CW = $clog2(MAX_ROW_LENGTH);

   logic [LABEL_WIDTH-1:0] middle_mem [MAX_ROW_LENGTH];
   logic [LABEL_WIDTH-1:0] upper_mem  [MAX_ROW_LENGTH];

   logic                   valid_ff, valid_in;
   step_flags_type         flags_ff;
   logic [CW-1:0]          col_ff;
   logic [LABEL_WIDTH-1:0] below_ff, centre_ff, right_ff, up_ff;
   logic [LABEL_WIDTH-1:0] below;
   logic                   up_fwd;

   assign below  = (flush || flags.blank) ? '0 : LABEL_WIDTH'(pixel_label);
   // with one-pixel rows the upper entry is rewritten on the same edge it is read
   assign up_fwd = move && (col_ff == col);

   assign valid_in = accept ? 1'b1 : (move ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         middle_mem[col] <= below;
         centre_ff       <= middle_mem[col];
         right_ff        <= middle_mem[col_next];
         up_ff           <= up_fwd ? centre_ff : upper_mem[col];
         below_ff        <= below;
         flags_ff        <= flags;
         col_ff          <= col;
      end
      if (move) begin
         upper_mem[col_ff] <= centre_ff;
      end
   end

   assign s1_valid  = valid_ff;
   assign s1_flags  = flags_ff;
   assign s1_below  = below_ff;
   assign s1_centre = centre_ff;
   assign s1_right  = right_ff;
   assign s1_up     = up_ff;

endmodule
`default_nettype wire

### rtl/lbe_edge_detect.sv
// Neighbour compare and result register of the label boundary eraser.
`default_nettype none
module lbe_edge_detect #(
   parameter int LABEL_WIDTH = lbe_pkg::LABEL_WIDTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          s1_valid,
   input  lbe_pkg::step_flags_type      s1_flags,
   input  wire  [LABEL_WIDTH-1:0]       s1_below,
   input  wire  [LABEL_WIDTH-1:0]       s1_centre,
   input  wire  [LABEL_WIDTH-1:0]       s1_right,
   input  wire  [LABEL_WIDTH-1:0]       s1_up,
   output logic                         move,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [lbe_pkg::PIXEL_W-1:0]  rsp_cleaned_label,
   output logic                         rsp_touched,
   output logic                         rsp_frame_last
);
   import lbe_pkg::*;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]     label_ff;
   logic                   touched_ff, last_ff;
   logic [LABEL_WIDTH-1:0] prev_centre_ff;
   logic [LABEL_WIDTH-1:0] up, left, right;
   logic                   out_free, hit;

   function automatic logic differs(input logic [LABEL_WIDTH-1:0] centre,
                                    input logic [LABEL_WIDTH-1:0] other);
      return (other != '0) && (other != centre);
   endfunction

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign move     = s1_valid && out_free;

   // left neighbour is the centre of the previous request in the row
   assign up    = s1_flags.up_valid  ? s1_up          : '0;
   assign left  = s1_flags.col_first ? '0             : prev_centre_ff;
   assign right = s1_flags.col_last  ? '0             : s1_right;
   assign hit   = (s1_centre != '0) &&
                  (differs(s1_centre, up) || differs(s1_centre, left) ||
                   differs(s1_centre, right) || differs(s1_centre, s1_below));

   assign rsp_valid_in = out_free ? (move && s1_flags.produce) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         prev_centre_ff <= s1_centre;
         label_ff       <= hit ? '0 : PIXEL_W'(s1_centre);
         touched_ff     <= hit;
         last_ff        <= s1_flags.frame_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cleaned_label = label_ff;
   assign rsp_touched       = touched_ff;
   assign rsp_frame_last    = last_ff;

endmodule
`default_nettype wire

### rtl/label_boundary_eraser.sv
// Top level of the 4-connected label boundary eraser.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_pixel_label, req_flush
//  rsp     | out       | rsp_valid/rsp_stall | rsp_cleaned_label, rsp_touched, rsp_frame_last
//  csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One request per clock while req_stall is low; a result leaves after its completing request
// through the registered row buffer read and then the result register.
// Results lag one row: row 0 of a slice gives none, flush requests drain the last row.
// Synchronous reset clears control only; row buffers need no clearing pass.
// req_stall rises only while the input stage is full and the result register is stalled.
`default_nettype none
module label_boundary_eraser #(
   parameter int MAX_ROW_LENGTH = lbe_pkg::MAX_ROW_LENGTH_DEF,
   parameter int LABEL_WIDTH    = lbe_pkg::LABEL_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [lbe_pkg::PIXEL_W-1:0]      req_pixel_label,
   input  wire                              req_flush,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [lbe_pkg::PIXEL_W-1:0]      rsp_cleaned_label,
   output logic                             rsp_touched,
   output logic                             rsp_frame_last,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [lbe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [lbe_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lbe_pkg::*;

   localparam int CW = $clog2(MAX_ROW_LENGTH);

   logic                   accept, move, s1_valid;
   logic [CW-1:0]          col, col_next;
   step_flags_type         flags, s1_flags;
   logic [LABEL_WIDTH-1:0] s1_below, s1_centre, s1_right, s1_up;

   assign req_stall = s1_valid && !move;
   assign accept    = req_valid && !req_stall;

   lbe_frame_ctrl #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH)
   ) u_frame_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .col       (col),
      .col_next  (col_next),
      .flags     (flags)
   );

   lbe_line_store #(
      .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
      .LABEL_WIDTH   (LABEL_WIDTH)
   ) u_line_store (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .move        (move),
      .pixel_label (req_pixel_label),
      .flush       (req_flush),
      .col         (col),
      .col_next    (col_next),
      .flags       (flags),
      .s1_valid    (s1_valid),
      .s1_flags    (s1_flags),
      .s1_below    (s1_below),
      .s1_centre   (s1_centre),
      .s1_right    (s1_right),
      .s1_up       (s1_up)
   );

   lbe_edge_detect #(
      .LABEL_WIDTH(LABEL_WIDTH)
   ) u_edge_detect (
      .clock             (clock),
      .reset             (reset),
      .s1_valid          (s1_valid),
      .s1_flags          (s1_flags),
      .s1_below          (s1_below),
      .s1_centre         (s1_centre),
      .s1_right          (s1_right),
      .s1_up             (s1_up),
      .move              (move),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cleaned_label (rsp_cleaned_label),
      .rsp_touched       (rsp_touched),
      .rsp_frame_last    (rsp_frame_last)
   );

endmodule
`default_nettype wire

### rtl/lbe_checker.sv
// Port-level checks of the label boundary eraser and their binding.
`default_nettype none
module lbe_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_stall,
   input wire                          rsp_valid,
   input wire                          rsp_stall,
   input wire [lbe_pkg::PIXEL_W-1:0]   rsp_cleaned_label,
   input wire                          rsp_touched,
   input wire                          rsp_frame_last
);
   import lbe_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cleaned_label) &&
                                 $stable(rsp_touched) && $stable(rsp_frame_last))
      else $error("stalled result changed");

   // a touched pixel always leaves as background
   a_touched_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_touched |-> rsp_cleaned_label == '0)
      else $error("touched pixel with nonzero label");

   // input back-pressure only when the result side is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result stall");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind label_boundary_eraser lbe_checker u_checker (.*);
`default_nettype wire
